@@ src/grvm_pkg.sv @@
// Shared constants and types of the grid ray visibility marcher.
`timescale 1ns / 1ps
package grvm_pkg;

  localparam int OP_W       = 2;
  localparam int COORD_W    = 5;
  localparam int KIND_W     = 2;
  localparam int FRAC_W     = 16;
  localparam int HEAD_W     = 16;
  localparam int COUNT_W    = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int SIZE_W     = 6;
  localparam int STEP_W     = 16;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_CAST  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [KIND_W-1:0] KIND_VOID     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WALKABLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OCCLUDER = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAY_LIMIT   = 3'd4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hFFFFF;

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b00_0000_0001,
    S_IDLE    = 10'b00_0000_0010,
    S_DECODE  = 10'b00_0000_0100,
    S_QUERY   = 10'b00_0000_1000,
    S_RAY_CHK = 10'b00_0001_0000,
    S_MARCH   = 10'b00_0010_0000,
    S_VIS_A   = 10'b00_0100_0000,
    S_VIS_B   = 10'b00_1000_0000,
    S_FINISH  = 10'b01_0000_0000,
    S_RESULT  = 10'b10_0000_0000
  } state_e;

endpackage

@@ src/grvm_if.sv @@
// Handshake channel interfaces for command beats and result beats.
`timescale 1ns / 1ps
interface grvm_in_if;
  logic                                valid;
  logic                                ready;
  logic [grvm_pkg::OP_W-1:0]           opcode;
  logic [grvm_pkg::COORD_W-1:0]        cell_x;
  logic [grvm_pkg::COORD_W-1:0]        cell_y;
  logic [grvm_pkg::KIND_W-1:0]         cell_kind;
  logic [grvm_pkg::FRAC_W-1:0]         offset_x;
  logic [grvm_pkg::FRAC_W-1:0]         offset_y;
  logic signed [grvm_pkg::HEAD_W-1:0]  heading_x;
  logic signed [grvm_pkg::HEAD_W-1:0]  heading_y;
  logic [grvm_pkg::COORD_W-1:0]        target_x;
  logic [grvm_pkg::COORD_W-1:0]        target_y;

  modport source (output valid, opcode, cell_x, cell_y, cell_kind, offset_x, offset_y,
                  heading_x, heading_y, target_x, target_y, input ready);
  modport sink (input valid, opcode, cell_x, cell_y, cell_kind, offset_x, offset_y,
                heading_x, heading_y, target_x, target_y, output ready);
endinterface

interface grvm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          visible;
  logic                          changed;
  logic                          rejected;
  logic [grvm_pkg::COUNT_W-1:0]  stall_count;
  logic                          search_done;

  modport source (output valid, visible, changed, rejected, stall_count, search_done,
                  input ready);
  modport sink (input valid, visible, changed, rejected, stall_count, search_done,
                output ready);
endinterface

@@ src/grvm_vis_mem.sv @@
// Simple dual-port visibility memory with one write port and a registered read port.
`timescale 1ns / 1ps
module grvm_vis_mem #(
  parameter int AW = 15,
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

@@ src/grid_ray_visibility_marcher.sv @@
// Top level of the grid ray visibility marcher: sequencer, layout memory and march datapath.
// An accepted ray marches step by step; every step that enters a new cell also passes
// S_VIS_A and S_VIS_B to mark both directions in the visibility memory.
// One beat is in work at a time; a result waits in an output register.
// After reset a clearing pass zeroes the visibility memory; configuration writes are
// taken during it.
`timescale 1ns / 1ps
module grid_ray_visibility_marcher #(
  parameter int GRID_SIDE = 32,
  parameter int MAX_STEPS = 65535
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  grvm_in_if.sink                            in_i,
  grvm_out_if.source                         out_o,
  input  logic                               cfg_we_i,
  input  logic [grvm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [grvm_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import grvm_pkg::*;

  localparam int XW     = $clog2(GRID_SIDE);
  localparam int CELL_W = 2 * XW;
  localparam int VIS_AW = 3 * XW;
  localparam int VIS_DW = 1 << XW;
  localparam int KW     = $clog2(MAX_STEPS + 1);
  localparam int PW     = 42;
  localparam int TW     = 24;
  localparam int QW     = 48;
  localparam logic [6:0] SIDE7 = 7'(GRID_SIDE);

  state_e state_q, state_d;

  logic [SIZE_W-1:0]  width_q, height_q;
  logic [STEP_W-1:0]  step_q;
  logic [COUNT_W-1:0] stall_lim_q, ray_lim_q;
  logic [COUNT_W-1:0] stall_cnt_q, ray_cnt_q;

  logic [OP_W-1:0]          op_q;
  logic [COORD_W-1:0]       cx_q, cy_q, tx_q, ty_q;
  logic [KIND_W-1:0]        kind_q;
  logic [FRAC_W-1:0]        offx_q, offy_q;
  logic signed [HEAD_W-1:0] hx_q, hy_q;

  logic res_vis_q, res_chg_q, res_rej_q, q_ok_q;
  logic out_valid_q, out_vis_q, out_chg_q, out_rej_q, out_done_q;
  logic [COUNT_W-1:0] out_stall_q;

  logic [VIS_AW-1:0] clr_q;
  logic [14:0]       diag_q;
  logic [TW-1:0]     t_q;
  logic [QW-1:0]     t2_q, u_q, du_q;
  logic [KW-1:0]     k_q;
  logic signed [PW-1:0] px_q, py_q;
  logic signed [32:0]   dx_q, dy_q;
  logic [CELL_W-1:0] dst_q, prev_q;
  logic              prev_v_q;

  logic [1:0]        lay_mem [2**CELL_W];
  logic [1:0]        lay_rdata_q;
  logic              lay_we, lay_re;
  logic [CELL_W-1:0] lay_raddr;

  logic              vis_we, vis_re;
  logic [VIS_AW-1:0] vis_waddr, vis_raddr;
  logic [VIS_DW-1:0] vis_wdata, vis_rdata;

  logic [6:0]        w_eff, h_eff;
  logic [STEP_W-1:0] len_eff;
  logic [XW-1:0]     cxc, cyc, txc, tyc, dst_x, dst_y;
  logic [CELL_W-1:0] src, dst;
  logic [9:0]        cur_tx, cur_ty;
  logic              stop, same, advance, fresh_a, fresh_b, out_free;
  logic [31:0]       lensq;

  always_comb begin
    w_eff   = (width_q == '0) ? 7'd1 : ((7'(width_q) > SIDE7) ? SIDE7 : 7'(width_q));
    h_eff   = (height_q == '0) ? 7'd1 : ((7'(height_q) > SIDE7) ? SIDE7 : 7'(height_q));
    len_eff = (step_q == '0) ? STEP_W'(1) : step_q;
    lensq   = 32'(len_eff) * 32'(len_eff);
    cxc     = XW'(cx_q);
    cyc     = XW'(cy_q);
    txc     = XW'(tx_q);
    tyc     = XW'(ty_q);
    src     = {cyc, cxc};
    cur_tx  = px_q[PW-2:31];
    cur_ty  = py_q[PW-2:31];
    dst_x   = XW'(cur_tx);
    dst_y   = XW'(cur_ty);
    dst     = {dst_y, dst_x};
    stop    = (k_q >= KW'(MAX_STEPS)) || t_q[23] || (t2_q >= QW'({diag_q, 32'b0})) ||
              px_q[PW-1] || py_q[PW-1] || (cur_tx >= 10'(w_eff)) || (cur_ty >= 10'(h_eff));
    same    = prev_v_q && (dst == prev_q);
    fresh_a = !vis_rdata[dst_q[XW-1:0]];
    fresh_b = !vis_rdata[cxc];
    advance = ((state_q == S_MARCH) && !stop && same) ||
              ((state_q == S_VIS_B) && (lay_rdata_q != KIND_OCCLUDER));
    out_free = !out_valid_q || out_o.ready;
  end

  // Memory port selection per sequencer state.
  always_comb begin
    lay_we    = 1'b0;
    lay_re    = 1'b0;
    lay_raddr = src;
    vis_we    = 1'b0;
    vis_waddr = {src, cyc};
    vis_wdata = '0;
    vis_re    = 1'b0;
    vis_raddr = {src, cyc};
    case (state_q)
      S_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_q;
      end
      S_DECODE: begin
        lay_we = (op_q == OP_LOAD) && ({2'b0, cx_q} < SIDE7) && ({2'b0, cy_q} < SIDE7);
        lay_re = (op_q == OP_CAST);
        vis_re = (op_q == OP_CAST) || (op_q == OP_QUERY);
        if (op_q == OP_QUERY) begin
          vis_raddr = {src, tyc};
        end
      end
      S_RAY_CHK: begin
        vis_we    = (lay_rdata_q == KIND_WALKABLE);
        vis_wdata = vis_rdata | (VIS_DW'(1) << cxc);
      end
      S_MARCH: begin
        lay_re    = !stop && !same;
        lay_raddr = dst;
        vis_re    = !stop && !same;
        vis_raddr = {src, dst_y};
      end
      S_VIS_A: begin
        vis_we    = 1'b1;
        vis_waddr = {src, dst_q[CELL_W-1:XW]};
        vis_wdata = vis_rdata | (VIS_DW'(1) << dst_q[XW-1:0]);
        vis_re    = 1'b1;
        vis_raddr = {dst_q, cyc};
      end
      S_VIS_B: begin
        vis_we    = 1'b1;
        vis_waddr = {dst_q, cyc};
        vis_wdata = vis_rdata | (VIS_DW'(1) << cxc);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:   if (&clr_q) state_d = S_IDLE;
      S_IDLE:    if (in_i.valid) state_d = S_DECODE;
      S_DECODE: begin
        if (op_q == OP_QUERY) begin
          state_d = S_QUERY;
        end else if ((op_q == OP_CAST) && ({2'b0, cx_q} < w_eff) && ({2'b0, cy_q} < h_eff)) begin
          state_d = S_RAY_CHK;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_QUERY:   state_d = S_RESULT;
      S_RAY_CHK: state_d = (lay_rdata_q == KIND_WALKABLE) ? S_MARCH : S_RESULT;
      S_MARCH: begin
        if (stop) begin
          state_d = S_FINISH;
        end else if (!same) begin
          state_d = S_VIS_A;
        end
      end
      S_VIS_A:   state_d = S_VIS_B;
      S_VIS_B:   state_d = (lay_rdata_q == KIND_OCCLUDER) ? S_FINISH : S_MARCH;
      S_FINISH:  state_d = S_RESULT;
      S_RESULT:  if (out_free) state_d = S_IDLE;
      default:   state_d = S_CLEAR;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      width_q     <= SIZE_W'(32);
      height_q    <= SIZE_W'(32);
      step_q      <= STEP_W'(66);
      stall_lim_q <= COUNT_W'(100000);
      ray_lim_q   <= COUNT_W'(1000000);
      stall_cnt_q <= '0;
      ray_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + VIS_AW'(1);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GRID_WIDTH:  width_q     <= cfg_data_i[SIZE_W-1:0];
          CFG_GRID_HEIGHT: height_q    <= cfg_data_i[SIZE_W-1:0];
          CFG_STEP_LENGTH: step_q      <= cfg_data_i[STEP_W-1:0];
          CFG_STALL_LIMIT: stall_lim_q <= cfg_data_i;
          CFG_RAY_LIMIT:   ray_lim_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_FINISH) begin
        if (ray_cnt_q != COUNT_MAX) ray_cnt_q <= ray_cnt_q + COUNT_W'(1);
        if (res_chg_q) begin
          stall_cnt_q <= '0;
        end else if (stall_cnt_q != COUNT_MAX) begin
          stall_cnt_q <= stall_cnt_q + COUNT_W'(1);
        end
      end
      if ((state_q == S_RESULT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q   <= in_i.opcode;
      cx_q   <= in_i.cell_x;
      cy_q   <= in_i.cell_y;
      kind_q <= in_i.cell_kind;
      offx_q <= in_i.offset_x;
      offy_q <= in_i.offset_y;
      hx_q   <= in_i.heading_x;
      hy_q   <= in_i.heading_y;
      tx_q   <= in_i.target_x;
      ty_q   <= in_i.target_y;
    end
    if (lay_we) begin
      lay_mem[src] <= (kind_q == KIND_UNUSED) ? KIND_VOID : kind_q;
    end
    if (lay_re) begin
      lay_rdata_q <= lay_mem[lay_raddr];
    end
    case (state_q)
      S_DECODE: begin
        res_vis_q <= 1'b0;
        res_chg_q <= 1'b0;
        res_rej_q <= (op_q == OP_CAST);
        q_ok_q    <= ({2'b0, cx_q} < SIDE7) && ({2'b0, cy_q} < SIDE7) &&
                     ({2'b0, tx_q} < SIDE7) && ({2'b0, ty_q} < SIDE7);
        diag_q    <= 15'(w_eff) * 15'(w_eff) + 15'(h_eff) * 15'(h_eff);
      end
      S_QUERY:   res_vis_q <= q_ok_q && vis_rdata[txc];
      S_RAY_CHK: begin
        res_rej_q <= (lay_rdata_q != KIND_WALKABLE);
        t_q       <= '0;
        t2_q      <= '0;
        u_q       <= QW'(lensq);
        du_q      <= QW'({lensq, 1'b0});
        k_q       <= '0;
        px_q      <= PW'({cx_q, offx_q, 15'b0});
        py_q      <= PW'({cy_q, offy_q, 15'b0});
        dx_q      <= hx_q * $signed({1'b0, len_eff});
        dy_q      <= hy_q * $signed({1'b0, len_eff});
        prev_v_q  <= 1'b0;
      end
      S_MARCH:   dst_q <= dst;
      S_VIS_A:   if (fresh_a) res_chg_q <= 1'b1;
      S_VIS_B: begin
        if (fresh_b) res_chg_q <= 1'b1;
        prev_q   <= dst_q;
        prev_v_q <= 1'b1;
      end
      default: ;
    endcase
    if (advance) begin
      k_q  <= k_q + KW'(1);
      t_q  <= t_q + TW'(len_eff);
      t2_q <= t2_q + u_q;
      u_q  <= u_q + du_q;
      px_q <= px_q + PW'(dx_q);
      py_q <= py_q + PW'(dy_q);
    end
    if ((state_q == S_RESULT) && out_free) begin
      out_vis_q   <= res_vis_q;
      out_chg_q   <= res_chg_q;
      out_rej_q   <= res_rej_q;
      out_stall_q <= stall_cnt_q;
      out_done_q  <= (ray_cnt_q >= ray_lim_q) || (stall_cnt_q >= stall_lim_q);
    end
  end

  grvm_vis_mem #(
    .AW(VIS_AW),
    .DW(VIS_DW)
  ) u_vis_mem (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .re_i    (vis_re),
    .raddr_i (vis_raddr),
    .rdata_o (vis_rdata)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.visible     = out_vis_q;
  assign out_o.changed     = out_chg_q;
  assign out_o.rejected    = out_rej_q;
  assign out_o.stall_count = out_stall_q;
  assign out_o.search_done = out_done_q;
endmodule

@@ src/grvm_checker.sv @@
// Port-level assertions for the grid ray visibility marcher and their binding.
`timescale 1ns / 1ps
module grvm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        visible_i,
  input logic        changed_i,
  input logic        rejected_i,
  input logic [19:0] stall_count_i
);
  // A result beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(stall_count_i) && $stable(changed_i))
    else $error("stalled result beat changed");

  a_rej_chg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && rejected_i |-> !changed_i)
    else $error("rejected ray reported a change");

  a_vis_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && visible_i |-> !changed_i && !rejected_i)
    else $error("visible bit set on a ray result");

  a_stall_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && changed_i |-> stall_count_i == 20'd0)
    else $error("stall count not cleared by a change");
endmodule

bind grid_ray_visibility_marcher grvm_checker u_grvm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .visible_i     (out_o.visible),
  .changed_i     (out_o.changed),
  .rejected_i    (out_o.rejected),
  .stall_count_i (out_o.stall_count)
);

@@ dv/grvm_tb_pkg.sv @@
// Beat types shared by the stimulus, the prediction and the checks of the testbench.
`timescale 1ns / 1ps
package grvm_tb_pkg;
  import grvm_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]           opcode;
    logic [COORD_W-1:0]        cell_x;
    logic [COORD_W-1:0]        cell_y;
    logic [KIND_W-1:0]         cell_kind;
    logic [FRAC_W-1:0]         offset_x;
    logic [FRAC_W-1:0]         offset_y;
    logic signed [HEAD_W-1:0]  heading_x;
    logic signed [HEAD_W-1:0]  heading_y;
    logic [COORD_W-1:0]        target_x;
    logic [COORD_W-1:0]        target_y;
  } cmd_t;

  typedef struct packed {
    logic               visible;
    logic               changed;
    logic               rejected;
    logic [COUNT_W-1:0] stall_count;
    logic               search_done;
  } res_t;

  typedef struct packed {
    cmd_t cmd;
    bit   fixed;
    res_t want;
  } row_t;

endpackage

@@ dv/testbench.sv @@
// Self-checking testbench of the grid ray visibility marcher with a built-in ray predictor.
`timescale 1ns / 1ps
module testbench;
  import grvm_pkg::*;
  import grvm_tb_pkg::*;

  localparam int SIDE = 32;
  localparam int STEP_CAP = 65535;
  localparam int AREA = 6;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  grvm_in_if  cmd_if ();
  grvm_out_if res_if ();

  grid_ray_visibility_marcher #(.GRID_SIDE(SIDE), .MAX_STEPS(STEP_CAP)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (cmd_if.sink),
    .out_o      (res_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  logic [KIND_W-1:0] layout_m [SIDE*SIDE];
  bit                sight_m  [SIDE*SIDE*SIDE*SIDE];
  int unsigned       stall_m;
  int unsigned       rays_m;
  int unsigned       width_m, height_m, step_m, stall_lim_m, ray_lim_m;

  res_t   pending_q [$];
  row_t   rows_q [$];
  int     fails;
  int     idle_mode;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int unsigned clamp_side(int unsigned v);
    if (v < 1) return 1;
    if (v > SIDE) return SIDE;
    return v;
  endfunction

  function automatic bit mark_sight(int unsigned src, int unsigned dst);
    bit fresh;
    fresh = !sight_m[src*SIDE*SIDE + dst];
    sight_m[src*SIDE*SIDE + dst] = 1'b1;
    return fresh;
  endfunction

  function automatic void march_ray(cmd_t c, output bit changed, output bit rejected);
    int unsigned w, h, src, len, tx, ty, dst;
    longint diag2, sx, sy, hx, hy, t, px, py;
    w = clamp_side(width_m);
    h = clamp_side(height_m);
    changed = 1'b0;
    rejected = 1'b0;
    if (c.cell_x >= w || c.cell_y >= h ||
        layout_m[c.cell_y*SIDE + c.cell_x] != KIND_WALKABLE) begin
      rejected = 1'b1;
      return;
    end
    src = c.cell_y*SIDE + c.cell_x;
    void'(mark_sight(src, src));
    len = (step_m == 0) ? 1 : step_m;
    diag2 = longint'(w*w + h*h) << 32;
    sx = ((longint'(c.cell_x) << 16) + longint'(c.offset_x)) * 32768;
    sy = ((longint'(c.cell_y) << 16) + longint'(c.offset_y)) * 32768;
    hx = longint'(c.heading_x);
    hy = longint'(c.heading_y);
    for (int k = 0; k < STEP_CAP; k++) begin
      t = longint'(k) * len;
      if (t >= (longint'(1) << 23) || t*t >= diag2) break;
      px = sx + hx*t;
      py = sy + hy*t;
      if (px < 0 || py < 0) break;
      tx = int'(px >>> 31);
      ty = int'(py >>> 31);
      if (tx >= w || ty >= h) break;
      dst = ty*SIDE + tx;
      if (mark_sight(src, dst)) changed = 1'b1;
      if (mark_sight(dst, src)) changed = 1'b1;
      if (layout_m[dst] == KIND_OCCLUDER) break;
    end
    if (rays_m < COUNT_MAX) rays_m++;
    if (changed) stall_m = 0;
    else if (stall_m < COUNT_MAX) stall_m++;
  endfunction

  function automatic res_t predict_result(cmd_t c);
    res_t r;
    bit ch, rj;
    r = '0;
    case (c.opcode)
      OP_LOAD: layout_m[c.cell_y*SIDE + c.cell_x] =
                 (c.cell_kind == KIND_UNUSED) ? KIND_VOID : c.cell_kind;
      OP_CAST: begin
        march_ray(c, ch, rj);
        r.changed = ch;
        r.rejected = rj;
      end
      OP_QUERY: r.visible = sight_m[(c.cell_y*SIDE + c.cell_x)*SIDE*SIDE +
                                    c.target_y*SIDE + c.target_x];
      default: ;
    endcase
    r.stall_count = stall_m[COUNT_W-1:0];
    r.search_done = (rays_m >= ray_lim_m) || (stall_m >= stall_lim_m);
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    fails++;
  endtask

  always @(negedge clk_i) begin
    if (idle_mode == 2) res_if.ready <= ($urandom_range(99) >= 62);
    else if (idle_mode == 3) res_if.ready <= ($urandom_range(99) >= 20);
    else res_if.ready <= 1'b1;
  end

  always @(posedge clk_i) begin
    res_t w;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        w = pending_q.pop_front();
        if (res_if.visible !== w.visible) report_mismatch("visible", res_if.visible, w.visible);
        if (res_if.changed !== w.changed) report_mismatch("changed", res_if.changed, w.changed);
        if (res_if.rejected !== w.rejected)
          report_mismatch("rejected", res_if.rejected, w.rejected);
        if (res_if.stall_count !== w.stall_count)
          report_mismatch("stall_count", res_if.stall_count, w.stall_count);
        if (res_if.search_done !== w.search_done)
          report_mismatch("search_done", res_if.search_done, w.search_done);
      end
    end
  end

  task automatic send_beat(cmd_t c, bit fixed, res_t want);
    int gap;
    res_t r;
    gap = (idle_mode == 1) ? 62 : (idle_mode == 3) ? 20 : 0;
    while ($urandom_range(99) < gap) begin
      @(negedge clk_i);
      cmd_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    cmd_if.valid     <= 1'b1;
    cmd_if.opcode    <= c.opcode;
    cmd_if.cell_x    <= c.cell_x;
    cmd_if.cell_y    <= c.cell_y;
    cmd_if.cell_kind <= c.cell_kind;
    cmd_if.offset_x  <= c.offset_x;
    cmd_if.offset_y  <= c.offset_y;
    cmd_if.heading_x <= c.heading_x;
    cmd_if.heading_y <= c.heading_y;
    cmd_if.target_x  <= c.target_x;
    cmd_if.target_y  <= c.target_y;
    do @(posedge clk_i); while (!cmd_if.ready);
    r = predict_result(c);
    pending_q = {pending_q, (fixed ? want : r)};
  endtask

  task automatic add_row(row_t r);
    rows_q = {rows_q, r};
  endtask

  task automatic drain_and_settle();
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CFG_DATA_W-1:0];
    case (idx)
      CFG_GRID_WIDTH:  width_m = value & 'h3F;
      CFG_GRID_HEIGHT: height_m = value & 'h3F;
      CFG_STEP_LENGTH: step_m = value & 'hFFFF;
      CFG_STALL_LIMIT: stall_lim_m = value & COUNT_MAX;
      CFG_RAY_LIMIT:   ray_lim_m = value & COUNT_MAX;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned s,
                           int unsigned sl, int unsigned rl);
    write_reg(CFG_GRID_WIDTH, w);
    write_reg(CFG_GRID_HEIGHT, h);
    write_reg(CFG_STEP_LENGTH, s);
    write_reg(CFG_STALL_LIMIT, sl);
    write_reg(CFG_RAY_LIMIT, rl);
  endtask

  function automatic cmd_t mk(logic [OP_W-1:0] op, int cx, int cy, logic [KIND_W-1:0] kind,
                              int ox, int oy, int hx, int hy, int tx, int ty);
    cmd_t c;
    c.opcode = op;
    c.cell_x = COORD_W'(cx);
    c.cell_y = COORD_W'(cy);
    c.cell_kind = kind;
    c.offset_x = FRAC_W'(ox);
    c.offset_y = FRAC_W'(oy);
    c.heading_x = HEAD_W'(hx);
    c.heading_y = HEAD_W'(hy);
    c.target_x = COORD_W'(tx);
    c.target_y = COORD_W'(ty);
    return c;
  endfunction

  function automatic row_t checked(cmd_t c);
    row_t r;
    r.cmd = c;
    r.fixed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    logic [127:0] noise;
    int pick, w, h;
    w = clamp_side(width_m);
    h = clamp_side(height_m);
    noise = {$urandom, $urandom, $urandom, $urandom};
    c = noise[$bits(cmd_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 10) begin
      c.opcode = OP_LOAD;
    end else if (pick < 65) begin
      c.opcode = OP_CAST;
      if ($urandom_range(9) < 8) begin
        for (int n = 0; n < 10; n++) begin
          c.cell_x = COORD_W'($urandom_range(w-1));
          c.cell_y = COORD_W'($urandom_range(h-1));
          if (layout_m[c.cell_y*SIDE + c.cell_x] == KIND_WALKABLE) break;
        end
      end
      if ($urandom_range(3) == 0) begin
        c.heading_x = $urandom_range(1) ? 16'sd32767 : -16'sd32768;
        c.heading_y = '0;
        if ($urandom_range(1)) {c.heading_x, c.heading_y} = {c.heading_y, c.heading_x};
      end
    end else if (pick < 95) begin
      c.opcode = OP_QUERY;
      if ($urandom_range(1)) begin
        c.cell_x = COORD_W'($urandom_range(w-1));
        c.cell_y = COORD_W'($urandom_range(h-1));
        c.target_x = COORD_W'($urandom_range(w-1));
        c.target_y = COORD_W'($urandom_range(h-1));
      end
    end else begin
      c.opcode = OP_NONE;
    end
    return c;
  endfunction

  initial begin
    row_t r;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    cmd_if.valid = 1'b0;
    cmd_if.opcode = OP_LOAD;
    cmd_if.cell_x = '0;
    cmd_if.cell_y = '0;
    cmd_if.cell_kind = KIND_VOID;
    cmd_if.offset_x = '0;
    cmd_if.offset_y = '0;
    cmd_if.heading_x = '0;
    cmd_if.heading_y = '0;
    cmd_if.target_x = '0;
    cmd_if.target_y = '0;
    res_if.ready = 1'b1;
    idle_mode = 0;
    fails = 0;
    foreach (layout_m[i]) layout_m[i] = KIND_VOID;
    foreach (sight_m[i]) sight_m[i] = 1'b0;
    stall_m = 0;
    rays_m = 0;
    width_m = 32;
    height_m = 32;
    step_m = 66;
    stall_lim_m = 100000;
    ray_lim_m = 1000000;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Straight after reset every counter and visibility bit is known to be clear.
    r = checked(mk(OP_QUERY, 0, 0, KIND_VOID, 0, 0, 0, 0, 0, 0));
    r.fixed = 1'b1;
    add_row(r);
    r = checked(mk(OP_NONE, 31, 31, KIND_UNUSED, 'hFFFF, 'hFFFF, -1, -1, 31, 31));
    r.fixed = 1'b1;
    add_row(r);
    foreach (rows_q[i]) send_beat(rows_q[i].cmd, rows_q[i].fixed, rows_q[i].want);
    rows_q.delete();

    // The whole area in use is written before any ray may read it.
    for (int y = 0; y < AREA; y++) begin
      for (int x = 0; x < AREA; x++) begin
        int p;
        p = $urandom_range(99);
        send_beat(mk(OP_LOAD, x, y, (p < 70) ? KIND_WALKABLE : (p < 85) ? KIND_OCCLUDER :
                     KIND_VOID, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      end
    end
    drain_and_settle();
    configure(AREA, AREA, 4096, COUNT_MAX, COUNT_MAX);

    add_row(checked(mk(OP_LOAD, 5, 5, KIND_WALKABLE, 0, 0, 0, 0, 0, 0)));
    add_row(checked(mk(OP_CAST, 5, 5, KIND_VOID, 0, 0, 32767, 0, 0, 0)));
    add_row(checked(mk(OP_CAST, 5, 5, KIND_VOID, 'hFFFF, 'hFFFF, -32768, 0, 0, 0)));
    add_row(checked(mk(OP_CAST, 5, 5, KIND_VOID, 'h8000, 'h8000, 0, 0, 0, 0)));
    add_row(checked(mk(OP_CAST, 5, 5, KIND_VOID, 'h8000, 0, 0, 32767, 0, 0)));
    add_row(checked(mk(OP_CAST, 5, 5, KIND_VOID, 0, 'hFFFF, 23170, -23170, 0, 0)));
    add_row(checked(mk(OP_LOAD, 3, 3, KIND_UNUSED, 0, 0, 0, 0, 0, 0)));
    add_row(checked(mk(OP_CAST, 3, 3, KIND_VOID, 0, 0, 32767, 0, 0, 0)));
    add_row(checked(mk(OP_LOAD, 4, 4, KIND_OCCLUDER, 0, 0, 0, 0, 0, 0)));
    add_row(checked(mk(OP_CAST, 4, 4, KIND_VOID, 0, 0, 32767, 0, 0, 0)));
    add_row(checked(mk(OP_CAST, 31, 2, KIND_VOID, 0, 0, 32767, 0, 0, 0)));
    add_row(checked(mk(OP_CAST, 5, 5, KIND_VOID, 'hFFFF, 'hFFFF, -23170, -23170, 0, 0)));
    add_row(checked(mk(OP_LOAD, 0, 0, KIND_OCCLUDER, 0, 0, 0, 0, 0, 0)));
    add_row(checked(mk(OP_LOAD, 1, 0, KIND_WALKABLE, 0, 0, 0, 0, 0, 0)));
    add_row(checked(mk(OP_CAST, 1, 0, KIND_VOID, 0, 'h8000, -32768, 0, 0, 0)));
    add_row(checked(mk(OP_CAST, 1, 0, KIND_VOID, 0, 'h8000, -32768, 0, 0, 0)));
    add_row(checked(mk(OP_QUERY, 5, 5, KIND_VOID, 0, 0, 0, 0, 5, 5)));
    add_row(checked(mk(OP_QUERY, 5, 5, KIND_VOID, 0, 0, 0, 0, 31, 5)));
    add_row(checked(mk(OP_QUERY, 31, 31, KIND_VOID, 0, 0, 0, 0, 0, 0)));
    add_row(checked(mk(OP_QUERY, 1, 0, KIND_VOID, 0, 0, 0, 0, 0, 0)));
    add_row(checked(mk(OP_NONE, 5, 5, KIND_WALKABLE, 0, 0, 0, 0, 0, 0)));
    foreach (rows_q[i]) send_beat(rows_q[i].cmd, rows_q[i].fixed, rows_q[i].want);
    drain_and_settle();

    // A one-column grid of full height with the smallest step and both limits at zero.
    configure(0, 63, 0, 0, 0);
    send_beat(mk(OP_LOAD, 0, 31, KIND_WALKABLE, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    send_beat(mk(OP_CAST, 0, 31, KIND_VOID, 'h1234, 'hF000, 1000, 32767, 0, 0), 1'b0, '0);
    send_beat(mk(OP_QUERY, 0, 31, KIND_VOID, 0, 0, 0, 0, 0, 31), 1'b0, '0);
    drain_and_settle();

    configure(5, 3, 66, 3, 5);
    for (int i = 0; i < 10; i++) send_beat(random_cmd(), 1'b0, '0);
    drain_and_settle();

    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = ph;
      if (ph == 3) configure(AREA, AREA, 65535, COUNT_MAX, COUNT_MAX);
      else configure(($urandom_range(9) == 0) ? 0 : $urandom_range(1, AREA),
                     $urandom_range(1, AREA), $urandom_range(2048, 65535),
                     $urandom_range(1, 40), $urandom_range(1, 40));
      for (int i = 0; i < 8; i++) send_beat(random_cmd(), 1'b0, '0);
      drain_and_settle();
    end

    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
